### design/pwc_pkg.sv
// ----------------------------------------------------------------------------
// pwc_pkg: shared types and constants for the clamped PID controller
// Holds the controller states, the datapath command and status groups,
// the register indexes and the fixed-point limits.
// ----------------------------------------------------------------------------
package pwc_pkg;

    localparam int ERR_W   = 16;   // error, signed Q11.4
    localparam int TS_W    = 16;   // time step, unsigned Q4.12
    localparam int GAIN_W  = 16;   // gains, signed Q8.8
    localparam int INTEG_W = 18;   // integral, signed Q9.8
    localparam int DRIVE_W = 11;   // drive, signed integer
    localparam int MUL_A_W = 17;
    localparam int MUL_B_W = 18;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int ISUM_W  = 27;   // integral plus floored product
    localparam int SUM_W   = 40;   // Q.16 sum of the three terms
    localparam int CFG_A_W = 2;

    localparam int INTEG_LIMIT = 128000;  // 500.0 in Q.8
    localparam int DRIVE_LIMIT = 999;

    typedef enum logic [CFG_A_W-1:0] {
        CFG_PROP_GAIN  = 2'd0,
        CFG_INTEG_GAIN = 2'd1,
        CFG_DERIV_GAIN = 2'd2
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_P,
        ST_MUL_I,
        ST_MUL_D,
        ST_FINAL
    } t_state;

    typedef enum logic [1:0] {
        MUL_ERR_TS,
        MUL_KP_ERR,
        MUL_KI_INT,
        MUL_KD_DIFF
    } t_mul_sel;

    typedef struct packed {
        logic     load_in;    // capture a new beat, start error times step
        logic     upd_integ;  // fold the product into the clamped integral
        logic     sum_init;   // start the sum with the proportional term
        logic     sum_acc;    // add the integral term
        logic     upd_prev;   // store the error as the last error
        logic     load_out;   // write the saturated drive to the output
        t_mul_sel mul_sel;
    } t_dp_cmd;

    typedef struct packed {
        logic out_valid;
    } t_dp_stat;

endpackage

### design/pwc_dp.sv
// ----------------------------------------------------------------------------
// pwc_dp: datapath of the clamped PID controller
// Gain registers, one shared signed multiplier with a product register,
// the integral and last-error state, the sum accumulator and the output
// register.
// ----------------------------------------------------------------------------
module pwc_dp import pwc_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_A_W-1:0]   i_cfg_addr,
    input  logic [GAIN_W-1:0]    i_cfg_wdata,
    input  logic [ERR_W-1:0]     i_error_in,
    input  logic [TS_W-1:0]      i_time_step,
    input  logic                 i_out_ready,
    input  t_dp_cmd              i_cmd,
    output t_dp_stat             o_stat,
    output logic [DRIVE_W-1:0]   o_drive
);

    localparam logic signed [ISUM_W-1:0] IntegHi = ISUM_W'(INTEG_LIMIT);
    localparam logic signed [ISUM_W-1:0] IntegLo = -IntegHi;
    localparam logic signed [SUM_W-17:0] DriveHi = (SUM_W-16)'(DRIVE_LIMIT);
    localparam logic signed [SUM_W-17:0] DriveLo = -DriveHi;

    logic signed [GAIN_W-1:0]  r_kp, r_ki, r_kd;
    logic signed [ERR_W-1:0]   r_err, r_prev;
    logic signed [INTEG_W-1:0] r_integ, n_integ;
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [SUM_W-1:0]   r_sum;
    logic [DRIVE_W-1:0]        r_drive, n_drive;
    logic                      r_out_valid;

    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  mul_p;
    logic signed [ERR_W:0]     err_diff;
    logic signed [ISUM_W-1:0]  integ_sum;
    logic signed [SUM_W-1:0]   prod_ext, prod_x16, total;
    logic signed [SUM_W-17:0]  drive_q;

    assign err_diff = {r_err[ERR_W-1], r_err} - {r_prev[ERR_W-1], r_prev};

    always_comb begin
        unique case (i_cmd.mul_sel)
            MUL_ERR_TS: begin
                mul_a = {i_error_in[ERR_W-1], i_error_in};
                mul_b = {2'b00, i_time_step};
            end
            MUL_KP_ERR: begin
                mul_a = {r_kp[GAIN_W-1], r_kp};
                mul_b = {{2{r_err[ERR_W-1]}}, r_err};
            end
            MUL_KI_INT: begin
                mul_a = {r_ki[GAIN_W-1], r_ki};
                mul_b = r_integ;
            end
            MUL_KD_DIFF: begin
                mul_a = {r_kd[GAIN_W-1], r_kd};
                mul_b = {err_diff[ERR_W], err_diff};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // Floor of the Q.16 product to Q.8 is an arithmetic drop of 8 bits.
    assign integ_sum = {{(ISUM_W-INTEG_W){r_integ[INTEG_W-1]}}, r_integ}
                     + signed'(r_prod[PROD_W-1:8]);

    always_comb begin
        if (integ_sum > IntegHi) begin
            n_integ = INTEG_W'(IntegHi);
        end else if (integ_sum < IntegLo) begin
            n_integ = INTEG_W'(IntegLo);
        end else begin
            n_integ = integ_sum[INTEG_W-1:0];
        end
    end

    assign prod_ext = {{(SUM_W-PROD_W){r_prod[PROD_W-1]}}, r_prod};
    assign prod_x16 = {prod_ext[SUM_W-5:0], 4'b0000};
    assign total    = r_sum + prod_x16;
    assign drive_q  = signed'(total[SUM_W-1:16]);

    always_comb begin
        if (drive_q > DriveHi) begin
            n_drive = DRIVE_W'(DriveHi);
        end else if (drive_q < DriveLo) begin
            n_drive = DRIVE_W'(DriveLo);
        end else begin
            n_drive = drive_q[DRIVE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp        <= '0;
            r_ki        <= '0;
            r_kd        <= '0;
            r_integ     <= '0;
            r_prev      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_PROP_GAIN:  r_kp <= i_cfg_wdata;
                    CFG_INTEG_GAIN: r_ki <= i_cfg_wdata;
                    CFG_DERIV_GAIN: r_kd <= i_cfg_wdata;
                    default: ;
                endcase
            end
            if (i_cmd.upd_integ) begin
                r_integ <= n_integ;
            end
            if (i_cmd.upd_prev) begin
                r_prev <= r_err;
            end
            priority if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_p;
        if (i_cmd.load_in) begin
            r_err <= i_error_in;
        end
        if (i_cmd.sum_init) begin
            r_sum <= prod_x16;
        end else if (i_cmd.sum_acc) begin
            r_sum <= r_sum + prod_ext;
        end
        if (i_cmd.load_out) begin
            r_drive <= n_drive;
        end
    end

    assign o_stat.out_valid = r_out_valid;
    assign o_drive          = r_drive;

endmodule

### design/pwc_ctrl.sv
// ----------------------------------------------------------------------------
// pwc_ctrl: sequencer of the clamped PID controller
// Steps the shared multiplier through its four products per beat and
// decides when a beat is taken and when the drive is written out.
// ----------------------------------------------------------------------------
module pwc_ctrl import pwc_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  logic     i_out_ready,
    input  t_dp_stat i_stat,
    output logic     o_in_ready,
    output t_dp_cmd  o_cmd
);

    t_state r_state, n_state;
    logic   out_free;

    assign out_free = !i_stat.out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_cmd.mul_sel = MUL_ERR_TS;
        o_in_ready  = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = ST_MUL_P;
                end
            end
            ST_MUL_P: begin
                o_cmd.upd_integ = 1'b1;
                o_cmd.mul_sel   = MUL_KP_ERR;
                n_state         = ST_MUL_I;
            end
            ST_MUL_I: begin
                o_cmd.sum_init = 1'b1;
                o_cmd.mul_sel  = MUL_KI_INT;
                n_state        = ST_MUL_D;
            end
            ST_MUL_D: begin
                o_cmd.sum_acc  = 1'b1;
                o_cmd.mul_sel  = MUL_KD_DIFF;
                n_state        = ST_FINAL;
            end
            ST_FINAL: begin
                // While the output is blocked the derivative product is formed
                // again each cycle, so the product register keeps it. The last
                // error moves only once the drive is written.
                o_cmd.mul_sel = MUL_KD_DIFF;
                if (out_free) begin
                    o_cmd.load_out = 1'b1;
                    o_cmd.upd_prev = 1'b1;
                    o_cmd.mul_sel  = MUL_ERR_TS;
                    o_in_ready     = 1'b1;
                    if (i_in_valid) begin
                        o_cmd.load_in = 1'b1;
                        n_state       = ST_MUL_P;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

### design/pid_with_clamps.sv
// ----------------------------------------------------------------------------
// pid_with_clamps: positional PID controller with anti-windup clamp
// Each input beat carries an error (signed Q11.4) and a time step
// (unsigned Q4.12). The block updates a clamped integral and returns one
// saturated integer drive beat per input beat.
//
// Usage:
//   The input channel (i_in_valid / o_in_ready) carries i_error_in and
//   i_time_step. The output channel (o_out_valid / i_out_ready) carries
//   o_drive. Gains are written through i_cfg_we / i_cfg_addr / i_cfg_wdata
//   while the block is idle; index 0 is the proportional gain, 1 the
//   integral gain and 2 the derivative gain, and index 3 is ignored.
//   The single shared multiplier forms error times step and the three
//   gain products in turn, so a new beat is not taken before the last
//   one is finished. A new beat is taken in the same cycle that the drive
//   is written to the output register, so back-to-back beats do not
//   wait in the idle step.
//   Reset (synchronous, active low) clears the gains, the integral, the
//   last error and the output valid.
//   When the receiver stalls, the finished drive waits in the output
//   register; the block still finishes the beat it holds and then waits
//   in its last step, with o_in_ready low, until the output is free.
// ----------------------------------------------------------------------------
module pid_with_clamps import pwc_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // Configuration write port
    input  logic               i_cfg_we,
    input  logic [CFG_A_W-1:0] i_cfg_addr,
    input  logic [GAIN_W-1:0]  i_cfg_wdata,
    // Input channel
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [ERR_W-1:0]   i_error_in,
    input  logic [TS_W-1:0]    i_time_step,
    // Output channel
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [DRIVE_W-1:0] o_drive
);

    // Commands from the sequencer and status back from the datapath are
    // the only connection between the two halves.
    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    // The sequencer walks these steps per beat: take the beat while the
    // multiplier forms error times step, then the proportional, integral
    // and derivative products, and finally the floor and saturation.
    pwc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (dp_stat),
        .o_in_ready  (o_in_ready),
        .o_cmd       (dp_cmd)
    );

    // The datapath holds the gains and the controller state. All terms are
    // summed exactly in Q.16 before the final floor, so only the output
    // clamp limits the drive.
    pwc_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_error_in  (i_error_in),
        .i_time_step (i_time_step),
        .i_out_ready (i_out_ready),
        .i_cmd       (dp_cmd),
        .o_stat      (dp_stat),
        .o_drive     (o_drive)
    );

    assign o_out_valid = dp_stat.out_valid;

endmodule

### design/pwc_checker.sv
// ----------------------------------------------------------------------------
// pwc_checker: port-level checks for the clamped PID controller
// Watches the handshakes and the drive range seen on the top-level ports.
// ----------------------------------------------------------------------------
module pwc_checker import pwc_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               o_in_ready,
    input  logic [ERR_W-1:0]   i_error_in,
    input  logic [TS_W-1:0]    i_time_step,
    input  logic               o_out_valid,
    input  logic               i_out_ready,
    input  logic [DRIVE_W-1:0] o_drive
);

    localparam logic signed [DRIVE_W-1:0] DriveMax = DRIVE_W'(DRIVE_LIMIT);

    // A stalled drive beat stays valid and unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_drive))
        else $error("drive beat dropped or changed while stalled");

    // A waiting input beat stays offered with the same payload.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_ready |=> i_in_valid && $stable(i_error_in)
                                   && $stable(i_time_step))
        else $error("input beat dropped or changed while waiting");

    // Every drive beat lies within the saturation limits.
    a_drive_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (signed'(o_drive) <= DriveMax)
                     && (signed'(o_drive) >= -DriveMax))
        else $error("drive outside the saturation range");

    // A taken input beat keeps the input closed while it is computed.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input reopened right after a beat was taken");

    // No drive beat may appear right after reset.
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

bind pid_with_clamps pwc_checker u_pwc_checker (.*);
